// ----- hw/rtl/mvmb_pkg.sv -----
// Shared codes and field widths for the matrix-vector multiply with bias.
package mvmb_pkg;

  localparam int KIND_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 7;

  // Input item kinds.
  localparam logic [KIND_W-1:0] KIND_WEIGHT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BIAS   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_VECTOR = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_ENABLE = 2'd2;

  // Register reset values.
  localparam logic [4:0] ROWS_RESET = 5'd16;
  localparam logic [6:0] COLS_RESET = 7'd64;

endpackage

// ----- hw/rtl/matrix_vector_multiply_bias_core.sv -----
// Matrix-vector multiply with per-row bias: top level around weight, bias and accumulator memories.
//
// Computes y[h] = bias[h] + sum_w W[h][w]*x[w] for each row in use, in fixed point: Q1.15
// weights, vector and bias, bias shifted to Q2.30, 40-bit Q10.30 accumulators that wrap.
// Weight (kind 0) and bias (kind 1) loads write their memory in the cycle of the transfer.
// A vector element (kind 2) inside the column count sweeps every row in use through one
// shared 16x16 multiplier, one row per cycle, as a read-modify-write of the accumulator
// memory: read (weight, bias, accumulator), multiply, add and write back. An element
// therefore holds the input until its sweep and the pipeline drain are done. Column 0
// restarts each sum from its bias, or from zero with bias_enable low. The element in the
// last column in use then reads the accumulators out, one row per output transfer; the
// final row carries last. The last result may still sit in the output register while the
// next input is taken. Elements with a column at or beyond the column count and kind 3
// items are dropped. rows_in_use of zero acts as one and is capped at min(MAX_ROWS, 16);
// cols_in_use of zero acts as one and is capped at min(MAX_COLS, 127). Loads outside the
// stores are dropped. Memories are not cleared: a column 0 element starts each accumulator
// in use afresh, and weight and bias entries hold only what loads wrote.
module matrix_vector_multiply_bias_core #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 64
) (
  input  logic               clk,
  input  logic               rst,
  // configuration write port
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_wr_data,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         kind,
  input  logic [3:0]         row_index,
  input  logic [5:0]         col_index,
  input  logic signed [15:0] value,
  // output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_row,
  output logic signed [39:0] sum,
  output logic               last
);

  localparam int ROW_LIM = (MAX_ROWS < 16) ? MAX_ROWS : 16;
  localparam int COL_LIM = (MAX_COLS < 127) ? MAX_COLS : 127;
  localparam int BR_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int AR_W    = (ROW_LIM > 1) ? $clog2(ROW_LIM) : 1;
  localparam int W_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int WA_W    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;

  localparam logic [4:0]  ROW_LIM_V  = 5'(ROW_LIM);
  localparam logic [6:0]  COL_LIM_V  = 7'(COL_LIM);
  localparam logic [6:0]  MAX_ROWS_V = 7'(MAX_ROWS);
  localparam logic [10:0] MAX_COLS_V = 11'(MAX_COLS);
  localparam logic [WA_W-1:0] STRIDE = WA_W'(MAX_COLS);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_EMIT} state_t;

  // configuration registers
  logic [4:0] rows_in_use;
  logic [6:0] cols_in_use;
  logic       bias_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= mvmb_pkg::ROWS_RESET;
      cols_in_use <= mvmb_pkg::COLS_RESET;
      bias_enable <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mvmb_pkg::CFG_ROWS_IN_USE: rows_in_use <= cfg_wr_data[4:0];
        mvmb_pkg::CFG_COLS_IN_USE: cols_in_use <= cfg_wr_data;
        mvmb_pkg::CFG_BIAS_ENABLE: bias_enable <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  // effective sizes
  logic [4:0] rows_eff;
  logic [6:0] cols_eff;

  always_comb begin
    priority if (rows_in_use == 5'd0) rows_eff = 5'd1;
    else if (rows_in_use > ROW_LIM_V)  rows_eff = ROW_LIM_V;
    else                               rows_eff = rows_in_use;
    priority if (cols_in_use == 7'd0)  cols_eff = 7'd1;
    else if (cols_in_use > COL_LIM_V)  cols_eff = COL_LIM_V;
    else                               cols_eff = cols_in_use;
  end

  // control state
  state_t            state;
  logic [4:0]        row_cnt;   // sweep row being read
  logic [4:0]        e_cnt;     // next row to read out
  logic              rd_pend;   // readout read in flight
  logic [4:0]        rd_row;
  logic              rd_last;
  logic signed [15:0] x_val;
  logic [5:0]        x_col;
  logic              x_col0;
  logic              x_emit;

  // pipeline
  logic              s1_v, s2_v;
  logic [4:0]        s1_row, s2_row;
  logic signed [31:0] prod;
  logic [39:0]       base;
  logic [39:0]       acc_sum;

  // memory read data
  logic [15:0]       w_rdata;
  logic [15:0]       b_rdata;
  logic [39:0]       acc_rdata;

  logic in_xfer, row_ok, col_ok, w_ld, b_ld, v_go;
  logic issue, emit_rd, acc_rd;
  logic [WA_W-1:0] w_waddr, w_raddr;
  logic [AR_W-1:0] acc_raddr;

  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign row_ok   = {3'b000, row_index} < MAX_ROWS_V;
  assign col_ok   = {5'b00000, col_index} < MAX_COLS_V;
  assign w_ld     = in_xfer && (kind == mvmb_pkg::KIND_WEIGHT) && row_ok && col_ok;
  assign b_ld     = in_xfer && (kind == mvmb_pkg::KIND_BIAS) && row_ok;
  assign v_go     = in_xfer && (kind == mvmb_pkg::KIND_VECTOR) &&
                    ({1'b0, col_index} < cols_eff);

  assign issue    = (state == ST_RUN) && (row_cnt < rows_eff);
  assign emit_rd  = (state == ST_EMIT) && !rd_pend && (e_cnt < rows_eff) &&
                    (!out_valid || out_ready);
  assign acc_rd   = issue || emit_rd;

  assign w_waddr   = WA_W'(row_index) * STRIDE + WA_W'(col_index);
  assign w_raddr   = WA_W'(row_cnt) * STRIDE + WA_W'(x_col);
  assign acc_raddr = (state == ST_EMIT) ? AR_W'(e_cnt) : AR_W'(row_cnt);

  // weight memory: written by loads, read once per swept row
  logic [15:0] weight_mem [W_DEPTH];

  always_ff @(posedge clk) begin
    if (w_ld) begin
      weight_mem[w_waddr] <= value;
    end
    if (issue) begin
      w_rdata <= weight_mem[w_raddr];
    end
  end

  // bias memory
  logic [15:0] bias_mem [MAX_ROWS];

  always_ff @(posedge clk) begin
    if (b_ld) begin
      bias_mem[BR_W'(row_index)] <= value;
    end
    if (issue) begin
      b_rdata <= bias_mem[BR_W'(row_cnt)];
    end
  end

  // accumulator memory: rows in a sweep are distinct, and the sweep drains before readout
  logic [39:0] acc_mem [ROW_LIM];

  always_ff @(posedge clk) begin
    if (s2_v) begin
      acc_mem[AR_W'(s2_row)] <= acc_sum;
    end
    if (acc_rd) begin
      acc_rdata <= acc_mem[acc_raddr];
    end
  end

  // multiply stage, then add and write back
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= issue;
      s2_v <= s1_v;
    end
    s1_row <= row_cnt;
    s2_row <= s1_row;
    if (s1_v) begin
      prod <= $signed(w_rdata) * x_val;
      if (!x_col0) begin
        base <= acc_rdata;
      end else if (bias_enable) begin
        base <= {{9{b_rdata[15]}}, b_rdata, 15'b0};
      end else begin
        base <= '0;
      end
    end
  end

  assign acc_sum = base + {{8{prod[31]}}, prod};

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row_cnt   <= '0;
      e_cnt     <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (v_go) begin
            x_val   <= value;
            x_col   <= col_index;
            x_col0  <= (col_index == 6'd0);
            x_emit  <= ({1'b0, col_index} == cols_eff - 7'd1);
            row_cnt <= '0;
            state   <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (issue) begin
            row_cnt <= row_cnt + 5'd1;
          end else if (!s1_v && !s2_v) begin
            if (x_emit) begin
              e_cnt <= '0;
              state <= ST_EMIT;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_EMIT: begin
          if (rd_pend) begin
            out_valid <= 1'b1;
            out_row   <= 4'(rd_row);
            sum       <= acc_rdata;
            last      <= rd_last;
            rd_pend   <= 1'b0;
            if (rd_last) begin
              state <= ST_IDLE;
            end
          end else if (emit_rd) begin
            rd_row  <= e_cnt;
            rd_last <= (e_cnt == rows_eff - 5'd1);
            e_cnt   <= e_cnt + 5'd1;
            rd_pend <= 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/mvmb_checker.sv -----
// Port-level checks for the matrix-vector multiply core, bound to the top level.
module mvmb_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [3:0]         out_row,
  input logic signed [39:0] sum,
  input logic               last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sum) && $stable(out_row) && $stable(last))
    else $error("output changed while stalled");

  // reset leaves the block empty and ready
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

  // no input transfer while a vector readout is in progress
  a_no_in_mid_readout: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> !in_ready)
    else $error("input taken during readout");

  // readout rows follow in order
  a_row_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> ##1 (out_valid && out_row == 4'($past(out_row, 2) + 4'd1)))
    else $error("readout row out of order");

endmodule

bind matrix_vector_multiply_bias_core mvmb_checker u_mvmb_checker (.*);
